>>> hw/rtl/dtcfs_pkg.sv
`timescale 1ns / 1ps

package dtcfs_pkg;

    // Default sizes of the store.
    localparam int MAX_COLS_DEF   = 256;
    localparam int MAX_ROWS_DEF   = 128;
    localparam int DEPTH_BITS_DEF = 24;

    // Field widths on the streams.
    localparam int KIND_W   = 3;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 7;
    localparam int GLYPH_W  = 8;
    localparam int DEPTH_W  = 24;
    localparam int STATUS_W = 3;

    // Text cursor widths.
    localparam int CUR_COL_W = 9;
    localparam int CUR_ROW_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_WIDTH_W  = 9;
    localparam int CFG_HEIGHT_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd1;
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 9'd80;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 8'd24;

    // Character codes.
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;
    localparam logic [GLYPH_W-1:0] GLYPH_NL    = 8'h0A;
    localparam logic [GLYPH_W-1:0] GLYPH_NUL   = 8'h00;
    localparam logic [GLYPH_W-1:0] GLYPH_LOW   = 8'd32;
    localparam logic [GLYPH_W-1:0] GLYPH_HIGH  = 8'd126;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 3'd0,
        KIND_DRAW  = 3'd1,
        KIND_ZDRAW = 3'd2,
        KIND_TEXT  = 3'd3,
        KIND_READ  = 3'd4
    } t_kind;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_WRITTEN  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_READ     = 3'd4;

    // Controller states.
    typedef enum logic [1:0] {
        ST_SWEEP = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2
    } t_state;

    // Write strobes toward the cell memories.
    typedef struct packed {
        logic glyph_we;
        logic depth_we;
    } t_mem_ctl;

endpackage

>>> hw/rtl/dtcfs_cfg_regs.sv
`timescale 1ns / 1ps

module dtcfs_cfg_regs #(
    parameter int MAX_COLS = dtcfs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = dtcfs_pkg::MAX_ROWS_DEF,
    parameter int WB       = 9,
    parameter int HB       = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dtcfs_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [dtcfs_pkg::CFG_DATA_W-1:0] i_data,
    output logic [WB-1:0]                    o_width,
    output logic [HB-1:0]                    o_height
);

    logic [dtcfs_pkg::CFG_WIDTH_W-1:0]  r_width;
    logic [dtcfs_pkg::CFG_HEIGHT_W-1:0] r_height;

    assign o_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dtcfs_pkg::WIDTH_RESET;
            r_height <= dtcfs_pkg::HEIGHT_RESET;
        end else if (i_valid) begin
            if (i_index == dtcfs_pkg::CFG_WIDTH) begin
                r_width <= i_data[dtcfs_pkg::CFG_WIDTH_W-1:0];
            end else if (i_index == dtcfs_pkg::CFG_HEIGHT) begin
                r_height <= i_data[dtcfs_pkg::CFG_HEIGHT_W-1:0];
            end
        end
    end

    // Clamp both sizes into one cell up to the full store.
    always_comb begin
        if (r_width == '0) begin
            o_width = WB'(1);
        end else if (WB'(r_width) > WB'(MAX_COLS)) begin
            o_width = WB'(MAX_COLS);
        end else begin
            o_width = WB'(r_width);
        end
        if (r_height == '0) begin
            o_height = HB'(1);
        end else if (HB'(r_height) > HB'(MAX_ROWS)) begin
            o_height = HB'(MAX_ROWS);
        end else begin
            o_height = HB'(r_height);
        end
    end

endmodule

>>> hw/rtl/dtcfs_cell_mem.sv
`timescale 1ns / 1ps

module dtcfs_cell_mem #(
    parameter int CELLS      = dtcfs_pkg::MAX_COLS_DEF * dtcfs_pkg::MAX_ROWS_DEF,
    parameter int AW         = 15,
    parameter int DEPTH_BITS = dtcfs_pkg::DEPTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  dtcfs_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]                 i_addr,
    input  logic [dtcfs_pkg::GLYPH_W-1:0] i_glyph,
    input  logic [DEPTH_BITS-1:0]         i_depth,
    output logic [dtcfs_pkg::GLYPH_W-1:0] o_glyph,
    output logic [DEPTH_BITS-1:0]         o_depth
);

    logic [dtcfs_pkg::GLYPH_W-1:0] r_glyph_mem [CELLS];
    logic [DEPTH_BITS-1:0]         r_depth_mem [CELLS];
    logic [dtcfs_pkg::GLYPH_W-1:0] r_rd_glyph;
    logic [DEPTH_BITS-1:0]         r_rd_depth;

    // Glyph store, one port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.glyph_we) begin
            r_glyph_mem[i_addr] <= i_glyph;
        end
        r_rd_glyph <= r_glyph_mem[i_addr];
    end

    // Depth store, one port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.depth_we) begin
            r_depth_mem[i_addr] <= i_depth;
        end
        r_rd_depth <= r_depth_mem[i_addr];
    end

    assign o_glyph = r_rd_glyph;
    assign o_depth = r_rd_depth;

endmodule

>>> hw/rtl/dtcfs_ctrl.sv
`timescale 1ns / 1ps

module dtcfs_ctrl #(
    parameter int MAX_COLS   = dtcfs_pkg::MAX_COLS_DEF,
    parameter int CELLS      = dtcfs_pkg::MAX_COLS_DEF * dtcfs_pkg::MAX_ROWS_DEF,
    parameter int AW         = 15,
    parameter int WB         = 9,
    parameter int HB         = 8,
    parameter int DEPTH_BITS = dtcfs_pkg::DEPTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [WB-1:0]                  i_width,
    input  logic [HB-1:0]                  i_height,
    // Request side.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dtcfs_pkg::KIND_W-1:0]   i_kind,
    input  logic [dtcfs_pkg::COL_W-1:0]    i_col,
    input  logic [dtcfs_pkg::ROW_W-1:0]    i_row,
    input  logic [dtcfs_pkg::GLYPH_W-1:0]  i_glyph,
    input  logic [dtcfs_pkg::DEPTH_W-1:0]  i_depth,
    input  logic                           i_text_start,
    // Result side.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dtcfs_pkg::GLYPH_W-1:0]  o_read_glyph,
    output logic                           o_screen_end,
    output logic [dtcfs_pkg::STATUS_W-1:0] o_status,
    // Cell memories.
    output dtcfs_pkg::t_mem_ctl            o_mem_ctl,
    output logic [AW-1:0]                  o_mem_addr,
    output logic [dtcfs_pkg::GLYPH_W-1:0]  o_mem_glyph,
    output logic [DEPTH_BITS-1:0]          o_mem_depth,
    input  logic [dtcfs_pkg::GLYPH_W-1:0]  i_mem_glyph,
    input  logic [DEPTH_BITS-1:0]          i_mem_depth
);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    dtcfs_pkg::t_state r_state, n_state;
    dtcfs_pkg::t_kind  r_kind, n_kind;
    logic [AW-1:0]     r_sweep, n_sweep;
    logic [AW-1:0]     r_addr, n_addr;
    logic [dtcfs_pkg::GLYPH_W-1:0] r_glyph, n_glyph;
    logic [DEPTH_BITS-1:0]         r_depth, n_depth;
    logic              r_end, n_end;

    logic [dtcfs_pkg::CUR_COL_W-1:0] r_cur_col, n_cur_col;
    logic [dtcfs_pkg::CUR_ROW_W-1:0] r_cur_row, n_cur_row;
    logic [dtcfs_pkg::COL_W-1:0]     r_org_col, n_org_col;
    logic                            r_stopped, n_stopped;
    logic [WB-1:0]                   r_rd_col, n_rd_col;
    logic [HB-1:0]                   r_rd_row, n_rd_row;

    logic                            r_out_valid, n_out_valid;
    logic [dtcfs_pkg::GLYPH_W-1:0]   r_out_glyph, n_out_glyph;
    logic                            r_out_end, n_out_end;
    logic [dtcfs_pkg::STATUS_W-1:0]  r_out_status, n_out_status;

    logic              out_free;
    logic              accept;
    logic [WB-1:0]     sel_col;
    logic [HB-1:0]     sel_row;
    logic [AW-1:0]     sel_ix;
    logic [DEPTH_BITS-1:0] in_depth;
    logic              cell_out;

    // Text cursor path.
    logic [dtcfs_pkg::CUR_COL_W-1:0] tx_cc0, tx_cc1, tx_ccn;
    logic [dtcfs_pkg::CUR_ROW_W-1:0] tx_cr0, tx_cr1;
    logic [dtcfs_pkg::COL_W-1:0]     tx_oc;
    logic                            tx_stop0, tx_stopn, tx_write;
    logic [dtcfs_pkg::STATUS_W-1:0]  tx_status;

    // Readout position path.
    logic              rd_restart, rd_in_win, rd_is_end;
    logic [WB-1:0]     rd_c;
    logic [HB-1:0]     rd_r;

    assign out_free = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign in_depth = DEPTH_BITS'(i_depth);
    assign cell_out = (WB'(i_col) >= i_width) || (HB'(i_row) >= i_height);
    assign sel_ix   = AW'((32'(sel_row) * MAX_COLS) + 32'(sel_col));

    // Text cursor: origin load, wrap, stop and advance.
    always_comb begin
        tx_cc0    = i_text_start ? {1'b0, i_col} : r_cur_col;
        tx_cr0    = i_text_start ? {1'b0, i_row} : r_cur_row;
        tx_oc     = i_text_start ? i_col : r_org_col;
        tx_stop0  = i_text_start ? 1'b0 : r_stopped;
        tx_cc1    = tx_cc0;
        tx_cr1    = tx_cr0;
        tx_ccn    = tx_cc0;
        tx_stopn  = tx_stop0;
        tx_write  = 1'b0;
        tx_status = dtcfs_pkg::STAT_NONE;
        if (!tx_stop0) begin
            if (i_glyph == dtcfs_pkg::GLYPH_NUL) begin
                tx_stopn = 1'b1;
            end else begin
                if (i_glyph == dtcfs_pkg::GLYPH_NL || WB'(tx_cc0) >= i_width) begin
                    tx_cc1 = {1'b0, tx_oc};
                    tx_cr1 = tx_cr0 + 1'b1;
                end
                tx_ccn = tx_cc1;
                if (HB'(tx_cr1) >= i_height) begin
                    tx_stopn = 1'b1;
                end else if (i_glyph inside {[dtcfs_pkg::GLYPH_LOW:dtcfs_pkg::GLYPH_HIGH]}) begin
                    if (WB'(tx_cc1) < i_width) begin
                        tx_write  = 1'b1;
                        tx_status = dtcfs_pkg::STAT_WRITTEN;
                    end else begin
                        tx_status = dtcfs_pkg::STAT_RANGE;
                    end
                    tx_ccn = tx_cc1 + 1'b1;
                end
            end
        end
    end

    // Readout: restart a stale pass, then cell or newline position.
    always_comb begin
        rd_restart = (r_rd_row >= i_height);
        rd_r       = rd_restart ? '0 : r_rd_row;
        rd_c       = rd_restart ? '0 : r_rd_col;
        rd_in_win  = (rd_c < i_width);
        rd_is_end  = (rd_r == i_height - 1'b1) && (rd_c == i_width - 1'b1);
    end

    // Cell selected for the current request.
    always_comb begin
        case (dtcfs_pkg::t_kind'(i_kind))
            dtcfs_pkg::KIND_TEXT: begin
                sel_col = WB'(tx_cc1);
                sel_row = HB'(tx_cr1);
            end
            dtcfs_pkg::KIND_READ: begin
                sel_col = rd_c;
                sel_row = rd_r;
            end
            default: begin
                sel_col = WB'(i_col);
                sel_row = HB'(i_row);
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtcfs_pkg::ST_SWEEP;
            r_sweep     <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_org_col   <= '0;
            r_stopped   <= 1'b1;
            r_rd_col    <= '0;
            r_rd_row    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_org_col   <= n_org_col;
            r_stopped   <= n_stopped;
            r_rd_col    <= n_rd_col;
            r_rd_row    <= n_rd_row;
            r_out_valid <= n_out_valid;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_addr       <= n_addr;
        r_glyph      <= n_glyph;
        r_depth      <= n_depth;
        r_end        <= n_end;
        r_out_glyph  <= n_out_glyph;
        r_out_end    <= n_out_end;
        r_out_status <= n_out_status;
    end

    // Next state, memory access and result load.
    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_kind       = r_kind;
        n_addr       = r_addr;
        n_glyph      = r_glyph;
        n_depth      = r_depth;
        n_end        = r_end;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_org_col    = r_org_col;
        n_stopped    = r_stopped;
        n_rd_col     = r_rd_col;
        n_rd_row     = r_rd_row;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_glyph  = r_out_glyph;
        n_out_end    = r_out_end;
        n_out_status = r_out_status;
        o_ready      = 1'b0;
        o_mem_ctl    = '0;
        o_mem_addr   = r_addr;
        o_mem_glyph  = r_glyph;
        o_mem_depth  = r_depth;

        case (r_state)
            // Walk every cell, writing a space and the far depth.
            dtcfs_pkg::ST_SWEEP: begin
                o_mem_ctl.glyph_we = 1'b1;
                o_mem_ctl.depth_we = 1'b1;
                o_mem_addr  = r_sweep;
                o_mem_glyph = dtcfs_pkg::GLYPH_SPACE;
                o_mem_depth = '1;
                if (r_sweep == LAST_CELL) begin
                    n_sweep = '0;
                    n_state = dtcfs_pkg::ST_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end

            // Take a request when the result register can hold its answer.
            dtcfs_pkg::ST_IDLE: begin
                o_ready     = out_free;
                o_mem_addr  = sel_ix;
                o_mem_glyph = i_glyph;
                o_mem_depth = in_depth;
                if (accept) begin
                    n_out_glyph  = '0;
                    n_out_end    = 1'b0;
                    n_out_status = dtcfs_pkg::STAT_NONE;
                    case (dtcfs_pkg::t_kind'(i_kind))
                        dtcfs_pkg::KIND_CLEAR: begin
                            n_out_valid  = 1'b1;
                            n_out_status = dtcfs_pkg::STAT_WRITTEN;
                            n_state      = dtcfs_pkg::ST_SWEEP;
                        end
                        dtcfs_pkg::KIND_DRAW: begin
                            n_out_valid = 1'b1;
                            if (cell_out) begin
                                n_out_status = dtcfs_pkg::STAT_RANGE;
                            end else begin
                                o_mem_ctl.glyph_we = 1'b1;
                                n_out_status = dtcfs_pkg::STAT_WRITTEN;
                            end
                        end
                        dtcfs_pkg::KIND_ZDRAW: begin
                            if (cell_out) begin
                                n_out_valid  = 1'b1;
                                n_out_status = dtcfs_pkg::STAT_RANGE;
                            end else begin
                                n_kind  = dtcfs_pkg::KIND_ZDRAW;
                                n_addr  = sel_ix;
                                n_glyph = i_glyph;
                                n_depth = in_depth;
                                n_state = dtcfs_pkg::ST_READ;
                            end
                        end
                        dtcfs_pkg::KIND_TEXT: begin
                            o_mem_ctl.glyph_we = tx_write;
                            n_cur_col    = tx_ccn;
                            n_cur_row    = tx_cr1;
                            n_org_col    = tx_oc;
                            n_stopped    = tx_stopn;
                            n_out_valid  = 1'b1;
                            n_out_status = tx_status;
                        end
                        dtcfs_pkg::KIND_READ: begin
                            if (rd_in_win) begin
                                n_kind  = dtcfs_pkg::KIND_READ;
                                n_addr  = sel_ix;
                                n_end   = rd_is_end;
                                n_state = dtcfs_pkg::ST_READ;
                                if (rd_is_end) begin
                                    n_rd_col = '0;
                                    n_rd_row = '0;
                                end else begin
                                    n_rd_col = rd_c + 1'b1;
                                    n_rd_row = rd_r;
                                end
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out_glyph  = dtcfs_pkg::GLYPH_NL;
                                n_out_status = dtcfs_pkg::STAT_READ;
                                n_rd_col     = '0;
                                n_rd_row     = rd_r + 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            // Stored cell is on the memory output; finish once the result fits.
            dtcfs_pkg::ST_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = dtcfs_pkg::ST_IDLE;
                    if (r_kind == dtcfs_pkg::KIND_ZDRAW) begin
                        n_out_glyph = '0;
                        n_out_end   = 1'b0;
                        if (r_depth >= i_mem_depth) begin
                            n_out_status = dtcfs_pkg::STAT_REJECTED;
                        end else begin
                            o_mem_ctl.glyph_we = 1'b1;
                            o_mem_ctl.depth_we = 1'b1;
                            n_out_status = dtcfs_pkg::STAT_WRITTEN;
                        end
                    end else begin
                        n_out_glyph  = i_mem_glyph;
                        n_out_end    = r_end;
                        n_out_status = dtcfs_pkg::STAT_READ;
                    end
                end
            end

            default: begin
                n_state = dtcfs_pkg::ST_SWEEP;
                n_sweep = '0;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_read_glyph = r_out_glyph;
    assign o_screen_end = r_out_end;
    assign o_status     = r_out_status;

endmodule

>>> hw/rtl/depth_tested_character_frame_store_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata col,row,glyph,depth; tuser kind,start
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata read_glyph; tlast screen_end; tuser status
// cfg      in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Draw, text, newline readout, out-of-window and unused-kind requests load the result
// register as they are taken. Depth-tested draws inside the window and cell readouts pass
// through the read state, as the cell memories have a registered read. A clear loads its
// result, then the sweep writes one cell per cycle with s_axis_tready low. Reset starts the
// same sweep, during which configuration writes are still taken.
// One result register sits on m_axis; a new request is taken while it is empty or drains.

module depth_tested_character_frame_store_top #(
    parameter int MAX_COLS   = dtcfs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = dtcfs_pkg::MAX_ROWS_DEF,
    parameter int DEPTH_BITS = dtcfs_pkg::DEPTH_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Requests.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] col, [14:8] row, [22:15] glyph, [46:23] depth, [47] zero
    input  logic [47:0]                      s_axis_tdata,
    // [2:0] kind, [3] text_start
    input  logic [3:0]                       s_axis_tuser,
    // Results.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] read_glyph
    output logic [7:0]                       m_axis_tdata,
    output logic                             m_axis_tlast,
    // [2:0] status
    output logic [2:0]                       m_axis_tuser,
    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dtcfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtcfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int WB    = ($clog2(MAX_COLS + 1) > dtcfs_pkg::CUR_COL_W) ?
                           $clog2(MAX_COLS + 1) : dtcfs_pkg::CUR_COL_W;
    localparam int HB    = ($clog2(MAX_ROWS + 1) > dtcfs_pkg::CUR_ROW_W) ?
                           $clog2(MAX_ROWS + 1) : dtcfs_pkg::CUR_ROW_W;

    logic [WB-1:0]                 width;
    logic [HB-1:0]                 height;
    dtcfs_pkg::t_mem_ctl           mem_ctl;
    logic [AW-1:0]                 mem_addr;
    logic [dtcfs_pkg::GLYPH_W-1:0] mem_wr_glyph, mem_rd_glyph;
    logic [DEPTH_BITS-1:0]         mem_wr_depth, mem_rd_depth;

    // Screen size registers.
    dtcfs_cfg_regs #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .WB       (WB),
        .HB       (HB)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cfg_valid),
        .o_ready  (o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_width  (width),
        .o_height (height)
    );

    // Glyph and depth stores.
    dtcfs_cell_mem #(
        .CELLS      (CELLS),
        .AW         (AW),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_glyph (mem_wr_glyph),
        .i_depth (mem_wr_depth),
        .o_glyph (mem_rd_glyph),
        .o_depth (mem_rd_depth)
    );

    // Request sequencer, cursors and result register.
    dtcfs_ctrl #(
        .MAX_COLS   (MAX_COLS),
        .CELLS      (CELLS),
        .AW         (AW),
        .WB         (WB),
        .HB         (HB),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (width),
        .i_height     (height),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_kind       (s_axis_tuser[2:0]),
        .i_col        (s_axis_tdata[7:0]),
        .i_row        (s_axis_tdata[14:8]),
        .i_glyph      (s_axis_tdata[22:15]),
        .i_depth      (s_axis_tdata[46:23]),
        .i_text_start (s_axis_tuser[3]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_read_glyph (m_axis_tdata),
        .o_screen_end (m_axis_tlast),
        .o_status     (m_axis_tuser),
        .o_mem_ctl    (mem_ctl),
        .o_mem_addr   (mem_addr),
        .o_mem_glyph  (mem_wr_glyph),
        .o_mem_depth  (mem_wr_depth),
        .i_mem_glyph  (mem_rd_glyph),
        .i_mem_depth  (mem_rd_depth)
    );

endmodule

>>> test/depth_tested_character_frame_store_top_test.sv
`timescale 1ns / 1ps

module depth_tested_character_frame_store_top_test;

    import dtcfs_pkg::*;

    localparam int CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;

    // Kinds that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;

    // Window settings of the random phases, raw register values.
    localparam int PHASES = 9;
    localparam logic [CFG_DATA_W-1:0] PHASE_W [PHASES] =
        '{9'd0, 9'd5, 9'd256, 9'd511, 9'd1, 9'd256, 9'd17, 9'd80, 9'd3};
    localparam logic [CFG_DATA_W-1:0] PHASE_H [PHASES] =
        '{9'd0, 9'd3, 9'd128, 9'd255, 9'd128, 9'd1, 9'd6, 9'h118, 9'd2};

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] glyph;
        logic [DEPTH_W-1:0] depth;
        logic               start;
    } frame_req_t;

    typedef struct {
        logic [GLYPH_W-1:0]  read_glyph;
        logic                screen_end;
        logic [STATUS_W-1:0] status;
    } frame_ans_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the frame store, the cursors and the window.
    logic [GLYPH_W-1:0]      shadow_glyph [CELLS];
    logic [DEPTH_W-1:0]      shadow_depth [CELLS];
    logic [CFG_WIDTH_W-1:0]  cfg_width = WIDTH_RESET;
    logic [CFG_HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
    logic [CUR_COL_W-1:0]    cur_col = '0;
    logic [CUR_ROW_W-1:0]    cur_row = '0;
    logic [COL_W-1:0]        org_col = '0;
    logic                    text_halted = 1'b1;
    logic [CUR_COL_W-1:0]    rd_col = '0;
    logic [ROW_W-1:0]        rd_row = '0;

    frame_ans_t pending_answers [$];
    int  errors = 0;
    int  items_sent = 0;
    int  hold_off_cycles = 0;
    int  clears_left = 6;
    bit  steady_flow = 1'b0;

    depth_tested_character_frame_store_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Window size as the block uses it, after clamping.
    function automatic int eff_cols();
        int w;
        w = int'(cfg_width);
        if (w < 1) w = 1;
        if (w > MAX_COLS_DEF) w = MAX_COLS_DEF;
        return w;
    endfunction

    function automatic int eff_rows();
        int h;
        h = int'(cfg_height);
        if (h < 1) h = 1;
        if (h > MAX_ROWS_DEF) h = MAX_ROWS_DEF;
        return h;
    endfunction

    function automatic void wipe_shadow();
        for (int i = 0; i < CELLS; i++) begin
            shadow_glyph[i] = GLYPH_SPACE;
            shadow_depth[i] = DEPTH_FAR;
        end
    endfunction

    // Works out the answer to one request and updates the shadow state.
    task automatic predict_answer(input frame_req_t r, output frame_ans_t a);
        int w;
        int h;
        int ix;
        w = eff_cols();
        h = eff_rows();
        a.read_glyph = GLYPH_NUL;
        a.screen_end = 1'b0;
        a.status = STAT_NONE;
        case (r.kind)
            KIND_CLEAR: begin
                wipe_shadow();
                a.status = STAT_WRITTEN;
            end
            KIND_DRAW, KIND_ZDRAW: begin
                if (int'(r.col) >= w || int'(r.row) >= h) begin
                    a.status = STAT_RANGE;
                end else begin
                    ix = int'(r.row) * MAX_COLS_DEF + int'(r.col);
                    if (r.kind == KIND_ZDRAW && r.depth >= shadow_depth[ix]) begin
                        a.status = STAT_REJECTED;
                    end else begin
                        shadow_glyph[ix] = r.glyph;
                        if (r.kind == KIND_ZDRAW) shadow_depth[ix] = r.depth;
                        a.status = STAT_WRITTEN;
                    end
                end
            end
            KIND_TEXT: begin
                if (r.start) begin
                    cur_col = CUR_COL_W'(r.col);
                    cur_row = CUR_ROW_W'(r.row);
                    org_col = r.col;
                    text_halted = 1'b0;
                end
                if (!text_halted) begin
                    if (r.glyph == GLYPH_NUL) begin
                        text_halted = 1'b1;
                    end else begin
                        // A newline or a full row moves to the origin column of the next row.
                        if (r.glyph == GLYPH_NL || int'(cur_col) >= w) begin
                            cur_col = CUR_COL_W'(org_col);
                            cur_row = cur_row + 1'b1;
                        end
                        if (int'(cur_row) >= h) begin
                            text_halted = 1'b1;
                        end else if (r.glyph >= GLYPH_LOW && r.glyph <= GLYPH_HIGH) begin
                            if (int'(cur_col) < w) begin
                                shadow_glyph[int'(cur_row) * MAX_COLS_DEF + int'(cur_col)] =
                                    r.glyph;
                                a.status = STAT_WRITTEN;
                            end else begin
                                a.status = STAT_RANGE;
                            end
                            cur_col = cur_col + 1'b1;
                        end
                    end
                end
            end
            KIND_READ: begin
                // A row left over from a taller window restarts the pass.
                if (int'(rd_row) >= h) begin
                    rd_row = '0;
                    rd_col = '0;
                end
                if (int'(rd_col) < w) begin
                    a.read_glyph = shadow_glyph[int'(rd_row) * MAX_COLS_DEF + int'(rd_col)];
                    if (int'(rd_row) == h - 1 && int'(rd_col) == w - 1) begin
                        a.screen_end = 1'b1;
                        rd_col = '0;
                        rd_row = '0;
                    end else begin
                        rd_col = rd_col + 1'b1;
                    end
                end else begin
                    a.read_glyph = GLYPH_NL;
                    rd_col = '0;
                    rd_row = rd_row + 1'b1;
                end
                a.status = STAT_READ;
            end
            default: ;
        endcase
    endtask

    // Offers one request after a random gap (none in steady flow) and records its answer once taken.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] col,
                                input logic [ROW_W-1:0] row, input logic [GLYPH_W-1:0] glyph,
                                input logic [DEPTH_W-1:0] depth, input logic start);
        int gap;
        frame_req_t r;
        frame_ans_t a;
        r.kind = kind;
        r.col = col;
        r.row = row;
        r.glyph = glyph;
        r.depth = depth;
        r.start = start;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, depth, glyph, row, col};
        s_axis_tuser  <= {start, kind};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_answer(r, a);
        pending_answers.push_back(a);
        items_sent++;
    endtask

    // Stops offering and waits until every answer has come back.
    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Writes both window registers back to back.
    task automatic set_window(input logic [CFG_DATA_W-1:0] w_raw,
                              input logic [CFG_DATA_W-1:0] h_raw);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= w_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_width = w_raw[CFG_WIDTH_W-1:0];
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= h_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_height = h_raw[CFG_HEIGHT_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    // Coordinates mostly inside the window, sometimes anywhere.
    function automatic logic [COL_W-1:0] pick_col();
        if ($urandom_range(0, 99) < 85) return COL_W'($urandom_range(0, eff_cols() - 1));
        return COL_W'($urandom);
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(0, 99) < 85) return ROW_W'($urandom_range(0, eff_rows() - 1));
        return ROW_W'($urandom);
    endfunction

    // A text string, usually from a fresh origin, sometimes ended by a zero byte.
    task automatic random_text();
        int len;
        int p;
        logic [GLYPH_W-1:0] g;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            p = $urandom_range(0, 99);
            if (p < 80) g = GLYPH_W'($urandom_range(GLYPH_LOW, GLYPH_HIGH));
            else if (p < 90) g = GLYPH_NL;
            else g = GLYPH_W'($urandom);
            send_request(KIND_TEXT, pick_col(), pick_row(), g, DEPTH_W'($urandom),
                         i == 0 && $urandom_range(0, 9) != 0);
        end
        if ($urandom_range(0, 1))
            send_request(KIND_TEXT, pick_col(), pick_row(), GLYPH_NUL, DEPTH_W'($urandom),
                         1'b0);
    endtask

    // Draws that often revisit a cell with a nearer, equal or farther depth.
    task automatic random_draws();
        int n;
        int p;
        logic [COL_W-1:0]   c;
        logic [ROW_W-1:0]   r;
        logic [DEPTH_W-1:0] d;
        n = $urandom_range(1, 6);
        c = pick_col();
        r = pick_row();
        d = DEPTH_W'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 6) begin
                c = pick_col();
                r = pick_row();
            end
            p = $urandom_range(0, 3);
            if (p == 0) d = DEPTH_W'($urandom);
            else if (p == 1) d = d - DEPTH_W'($urandom_range(0, 1000));
            else if (p == 2) d = d + DEPTH_W'($urandom_range(1, 1000));
            send_request($urandom_range(0, 1) ? KIND_ZDRAW : KIND_DRAW, c, r,
                         GLYPH_W'($urandom), d, 1'($urandom));
        end
    endtask

    // Mixed traffic of well-formed sequences with some noise.
    task automatic random_traffic(input int count);
        int target;
        int p;
        int n;
        target = items_sent + count;
        while (items_sent < target) begin
            p = $urandom_range(0, 99);
            if (p < 30) begin
                random_text();
            end else if (p < 55) begin
                random_draws();
            end else if (p < 80) begin
                n = $urandom_range(1, 40);
                repeat (n)
                    send_request(KIND_READ, COL_W'($urandom), ROW_W'($urandom),
                                 GLYPH_W'($urandom), DEPTH_W'($urandom), 1'($urandom));
            end else if (p < 82 && clears_left > 0) begin
                clears_left--;
                send_request(KIND_CLEAR, COL_W'($urandom), ROW_W'($urandom),
                             GLYPH_W'($urandom), DEPTH_W'($urandom), 1'($urandom));
            end else begin
                send_request(KIND_W'($urandom_range(KIND_DRAW, KIND_SPARE_HI)),
                             COL_W'($urandom), ROW_W'($urandom), GLYPH_W'($urandom),
                             DEPTH_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // A first readout, then plain draws at the corners of the window and just outside it.
    task automatic test_cell_draws();
        send_request(KIND_READ, '0, '0, '0, '0, 1'b0);
        send_request(KIND_DRAW, 8'd0, 7'd0, 8'hFF, '0, 1'b0);
        send_request(KIND_DRAW, 8'd79, 7'd23, GLYPH_NUL, DEPTH_FAR, 1'b1);
        send_request(KIND_DRAW, 8'd80, 7'd0, "a", '0, 1'b0);
        send_request(KIND_DRAW, 8'd0, 7'd24, "b", '0, 1'b0);
        send_request(KIND_DRAW, 8'd255, 7'd127, "c", '0, 1'b0);
    endtask

    // Only a strictly nearer depth may replace the stored one.
    task automatic test_depth_rule();
        send_request(KIND_ZDRAW, 8'd1, 7'd0, "z", DEPTH_FAR, 1'b0);
        send_request(KIND_ZDRAW, 8'd1, 7'd0, "y", DEPTH_FAR - 1'b1, 1'b0);
        send_request(KIND_ZDRAW, 8'd1, 7'd0, "x", DEPTH_FAR - 1'b1, 1'b0);
        send_request(KIND_ZDRAW, 8'd1, 7'd0, "w", '0, 1'b0);
        send_request(KIND_ZDRAW, 8'd80, 7'd0, "v", '0, 1'b0);
    endtask

    // Text wrap, control bytes, stop at the bottom and an origin past the width.
    task automatic test_text_cursor();
        send_request(KIND_TEXT, 8'd78, 7'd0, "A", '0, 1'b1);
        send_request(KIND_TEXT, '0, '0, "B", '0, 1'b0);
        send_request(KIND_TEXT, '0, '0, "C", '0, 1'b0);
        send_request(KIND_TEXT, '0, '0, GLYPH_NL, '0, 1'b0);
        send_request(KIND_TEXT, '0, '0, GLYPH_HIGH + 1'b1, '0, 1'b0);
        send_request(KIND_TEXT, '0, '0, GLYPH_LOW - 1'b1, '0, 1'b0);
        send_request(KIND_TEXT, '0, '0, GLYPH_NUL, '0, 1'b0);
        send_request(KIND_TEXT, '0, '0, "D", '0, 1'b0);
        send_request(KIND_TEXT, 8'd200, 7'd0, "Q", '0, 1'b1);
        send_request(KIND_TEXT, 8'd0, 7'd23, "x", '0, 1'b1);
        send_request(KIND_TEXT, '0, '0, GLYPH_NL, '0, 1'b0);
        send_request(KIND_TEXT, '0, '0, "y", '0, 1'b0);
    endtask

    // Spare kinds change nothing; a clear restores spaces everywhere.
    task automatic test_spare_kinds_and_clear();
        send_request(KIND_SPARE_LO, 8'd0, 7'd0, "s", '0, 1'b1);
        send_request(KIND_SPARE_LO + 1'b1, 8'd0, 7'd0, "t", '0, 1'b0);
        send_request(KIND_SPARE_HI, 8'd0, 7'd0, "u", '0, 1'b1);
        send_request(KIND_CLEAR, '0, '0, '0, '0, 1'b0);
        send_request(KIND_READ, '0, '0, '0, '0, 1'b0);
    endtask

    // The receiver holds off while requests keep coming.
    task automatic test_backpressure();
        settle_outputs();
        steady_flow = 1'b1;
        hold_off_cycles = 200;
        for (int i = 0; i < 24; i++)
            send_request(i[0] ? KIND_READ : KIND_DRAW, pick_col(), pick_row(),
                         GLYPH_W'($urandom), DEPTH_W'($urandom), 1'b0);
        steady_flow = 1'b0;
    endtask

    // Random traffic under a series of window sizes, extremes included.
    task automatic test_window_settings();
        for (int p = 0; p < PHASES; p++) begin
            settle_outputs();
            set_window(PHASE_W[p], PHASE_H[p]);
            steady_flow = (p % 3 == 2);
            random_traffic(70);
        end
        steady_flow = 1'b0;
    endtask

    // Main sequence.
    initial begin
        wipe_shadow();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cell_draws();
        test_depth_rule();
        test_text_cursor();
        test_spare_kinds_and_clear();
        test_backpressure();
        test_window_settings();
        settle_outputs();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random stalls, a long hold-off on request, and the checks.
    initial begin : result_checker
        frame_ans_t want;
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end
            stall = steady_flow ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, glyph %h end %b status %0d", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata !== want.read_glyph) begin
                    $display("%0t: read_glyph expected %h actual %h", $time,
                             want.read_glyph, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.screen_end) begin
                    $display("%0t: screen_end expected %b actual %b", $time,
                             want.screen_end, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #(20_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dtcfs_pkg.sv
hw/rtl/dtcfs_cfg_regs.sv
hw/rtl/dtcfs_cell_mem.sv
hw/rtl/dtcfs_ctrl.sv
hw/rtl/depth_tested_character_frame_store_top.sv
test/depth_tested_character_frame_store_top_test.sv
